>>> hdl/ikw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ikw_pkg
// Shared types, character classes and the keyword table of the identifier
// and keyword scanner.
// ----------------------------------------------------------------------------
package ikw_pkg;

  localparam int unsigned PrefixDepth  = 8;
  localparam int unsigned PrefixW      = 8 * PrefixDepth;
  localparam int unsigned KwCount      = 31;
  localparam int unsigned KwIdxW       = 5;
  localparam int unsigned TokLenW      = 6;
  localparam int unsigned CoordW       = 16;

  localparam logic [7:0] CharQuestion   = 8'h3f;
  localparam logic [7:0] CharUnderscore = 8'h5f;

  // prefix holds the word's first characters, latest one in the low byte,
  // so a word of n characters lines up with a right-justified string literal
  localparam logic [PrefixW-1:0] KwText [KwCount] = '{
    64'("do"),     64'("if"),     64'("for"),    64'("int"),
    64'("char"),   64'("void"),   64'("else"),   64'("enum"),
    64'("long"),   64'("quad"),   64'("bool"),   64'("case"),
    64'("type"),   64'("goto"),   64'("uint"),
    64'("const"),  64'("float"),  64'("infer"),  64'("short"),
    64'("uchar"),  64'("ulong"),  64'("error"),  64'("while"),
    64'("return"), 64'("struct"), 64'("double"), 64'("static"),
    64'("switch"), 64'("ushort"),
    64'("default"), 64'("continue")
  };

  localparam logic [3:0] KwLen [KwCount] = '{
    4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd8
  };

  typedef struct packed {
    logic [PrefixW-1:0] prefix;
    logic [3:0]         len_lo;
    logic               long_word;
    logic               last_q;
    logic [TokLenW-1:0] len6;
    logic [CoordW-1:0]  line;
    logic [CoordW-1:0]  col;
  } cand_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_start_char(input logic [7:0] c);
    return is_letter(c) || (c == CharUnderscore);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_start_char(c) || is_digit(c) || (c == CharQuestion);
  endfunction

endpackage
`default_nettype wire

>>> hdl/ikw_collector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ikw_collector
// Word collection state and the token candidate register; one character is
// taken per cycle while no candidate waits; finished words become candidates.
// ----------------------------------------------------------------------------
module ikw_collector import ikw_pkg::*; #(
  parameter int unsigned MAX_WORD_LEN = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              char_valid_i,
  output      logic              char_ready_o,
  input  wire logic [7:0]        ch_i,
  input  wire logic [CoordW-1:0] line_i,
  input  wire logic [CoordW-1:0] col_i,
  output      logic              cand_valid_o,
  input  wire logic              cand_ready_i,
  output      cand_t             cand_o
);

  localparam int unsigned LenW = $clog2(MAX_WORD_LEN + 1);

  logic [PrefixW-1:0] prefix_q, prefix_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               in_word_q, in_word_d;
  logic               last_q_q, last_q_d;
  logic [CoordW-1:0]  line_q, line_d;
  logic [CoordW-1:0]  col_q, col_d;
  logic               cand_valid_q, cand_valid_d;
  cand_t              cand_q, cand_d;

  logic               accept;
  logic               take;
  logic [LenW-1:0]    base_len;
  logic [PrefixW-1:0] base_prefix;
  logic [LenW-1:0]    take_len;
  logic [PrefixW-1:0] take_prefix;
  logic               take_last_q;
  logic [CoordW-1:0]  take_line;
  logic [CoordW-1:0]  take_col;

  function automatic cand_t make_cand(input logic [PrefixW-1:0] p,
                                      input logic [LenW-1:0]    n,
                                      input logic               lq,
                                      input logic [CoordW-1:0]  ln,
                                      input logic [CoordW-1:0]  cl);
    cand_t                   c;
    logic [LenW+TokLenW-1:0] n_ext;
    n_ext       = {{TokLenW{1'b0}}, n};
    c.prefix    = p;
    c.len_lo    = n[3:0];
    c.long_word = (n_ext > (LenW + TokLenW)'(PrefixDepth));
    c.last_q    = lq;
    c.len6      = n_ext[TokLenW-1:0];
    c.line      = ln;
    c.col       = cl;
    return c;
  endfunction

  assign char_ready_o = !cand_valid_q || cand_ready_i;
  assign accept       = char_valid_i && char_ready_o;

  assign take = in_word_q ? is_word_char(ch_i) : is_start_char(ch_i);
  assign base_len    = in_word_q ? len_q : '0;
  assign base_prefix = in_word_q ? prefix_q : '0;
  assign take_len    = base_len + LenW'(1);
  assign take_prefix = (base_len < LenW'(PrefixDepth)) ?
                       {base_prefix[PrefixW-9:0], ch_i} : base_prefix;
  assign take_last_q = (ch_i == CharQuestion);
  assign take_line   = in_word_q ? line_q : line_i;
  assign take_col    = in_word_q ? col_q : col_i;

  always_comb begin
    prefix_d     = prefix_q;
    len_d        = len_q;
    in_word_d    = in_word_q;
    last_q_d     = last_q_q;
    line_d       = line_q;
    col_d        = col_q;
    cand_valid_d = cand_valid_q && !cand_ready_i;
    cand_d       = cand_q;
    if (accept) begin
      if (take) begin
        line_d = take_line;
        col_d  = take_col;
        if (take_len >= LenW'(MAX_WORD_LEN)) begin
          cand_valid_d = 1'b1;
          cand_d       = make_cand(take_prefix, take_len, take_last_q,
                                   take_line, take_col);
          prefix_d     = '0;
          len_d        = '0;
          in_word_d    = 1'b0;
          last_q_d     = 1'b0;
        end else begin
          prefix_d  = take_prefix;
          len_d     = take_len;
          in_word_d = 1'b1;
          last_q_d  = take_last_q;
        end
      end else if (in_word_q) begin
        cand_valid_d = 1'b1;
        cand_d       = make_cand(prefix_q, len_q, last_q_q, line_q, col_q);
        prefix_d     = '0;
        len_d        = '0;
        in_word_d    = 1'b0;
        last_q_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q     <= '0;
      len_q        <= '0;
      in_word_q    <= 1'b0;
      last_q_q     <= 1'b0;
      line_q       <= '0;
      col_q        <= '0;
      cand_valid_q <= 1'b0;
    end else begin
      prefix_q     <= prefix_d;
      len_q        <= len_d;
      in_word_q    <= in_word_d;
      last_q_q     <= last_q_d;
      line_q       <= line_d;
      col_q        <= col_d;
      cand_valid_q <= cand_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_o       = cand_q;

endmodule
`default_nettype wire

>>> hdl/ikw_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ikw_matcher
// Parallel compare of a finished word against the keyword table.
// ----------------------------------------------------------------------------
module ikw_matcher import ikw_pkg::*; (
  input  wire cand_t             cand_i,
  output      logic [KwIdxW-1:0] keyword_index_o
);

  logic [KwCount-1:0] hit;

  always_comb begin
    for (int i = 0; i < KwCount; i++) begin
      hit[i] = (cand_i.len_lo == KwLen[i]) && (cand_i.prefix == KwText[i]);
    end
  end

  always_comb begin
    keyword_index_o = '0;
    if (!cand_i.last_q && !cand_i.long_word) begin
      for (int i = KwCount - 1; i >= 0; i--) begin
        if (hit[i]) begin
          keyword_index_o = KwIdxW'(i + 1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/identifier_keyword_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// identifier_keyword_scanner
// Streaming identifier and keyword scanner: one character per transfer in,
// one token per finished word out.
// ----------------------------------------------------------------------------
// throughput: one character accepted every cycle while the output drains
// output path: the word's token is put in the candidate register when the
//   character that ends its word is accepted, then in the output register
// reset: asynchronous active low, clears the word state and both valid flags
// ----------------------------------------------------------------------------
module identifier_keyword_scanner import ikw_pkg::*; #(
  parameter int unsigned MAX_WORD_LEN = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // ch [7:0], line_number [23:8], column [39:24]
  input  wire logic [39:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // keyword_index [4:0], token_length [10:5], token_line [26:11],
  // start_column [42:27], zero [47:43]
  output      logic [47:0] m_axis_tdata
);

  logic              cand_valid;
  logic              cand_ready;
  cand_t             cand;
  logic [KwIdxW-1:0] kw_idx;

  logic              out_valid_q, out_valid_d;
  logic [42:0]       out_q, out_d;

  ikw_collector #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_collector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(s_axis_tvalid),
    .char_ready_o(s_axis_tready),
    .ch_i        (s_axis_tdata[7:0]),
    .line_i      (s_axis_tdata[23:8]),
    .col_i       (s_axis_tdata[39:24]),
    .cand_valid_o(cand_valid),
    .cand_ready_i(cand_ready),
    .cand_o      (cand)
  );

  ikw_matcher u_matcher (
    .cand_i         (cand),
    .keyword_index_o(kw_idx)
  );

  assign cand_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cand_ready) begin
      out_valid_d = cand_valid;
      out_d       = {cand.col, cand.line, cand.len6, kw_idx};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

endmodule
`default_nettype wire

>>> sim/identifier_keyword_scanner_checker.sv
// ----------------------------------------------------------------------------
// identifier_keyword_scanner_checker
// Watches both stream channels of the scanner, keeps its own word state and
// keyword table, works out the token each accepted character should cause and
// compares every token leaving the block against the oldest one predicted.
// ----------------------------------------------------------------------------
module identifier_keyword_scanner_checker
  import ikw_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // ch [7:0], line_number [23:8], column [39:24]
  input  logic [39:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // keyword_index [4:0], token_length [10:5], token_line [26:11],
  // start_column [42:27], zero [47:43]
  input  logic [47:0] m_tdata_i,
  output int          error_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CoordW-1:0]  col;
    logic [CoordW-1:0]  line;
    logic [TokLenW-1:0] len;
    logic [KwIdxW-1:0]  kw;
  } token_t;

  string kw_words [KwCount] = '{
    "do", "if", "for", "int",
    "char", "void", "else", "enum", "long", "quad", "bool", "case",
    "type", "goto", "uint",
    "const", "float", "infer", "short", "uchar", "ulong", "error", "while",
    "return", "struct", "double", "static", "switch", "ushort",
    "default", "continue"
  };

  logic [7:0]        prefix [PrefixDepth];
  int unsigned       word_len;
  bit                open_word;
  bit                ends_in_q;
  logic [CoordW-1:0] word_line;
  logic [CoordW-1:0] word_col;
  token_t            expected_tokens [$];
  int                fail_tally;

  function automatic bit is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic bit opens_word(input logic [7:0] c);
    return is_alpha(c) || (c == CharUnderscore);
  endfunction

  function automatic logic [KwIdxW-1:0] lookup_keyword();
    bit same;
    if (ends_in_q || (word_len > PrefixDepth)) return '0;
    for (int i = 0; i < KwCount; i++) begin
      if (kw_words[i].len() != word_len) continue;
      same = 1'b1;
      for (int k = 0; k < word_len; k++) begin
        if (kw_words[i][k] != prefix[k]) same = 1'b0;
      end
      if (same) return KwIdxW'(i + 1);
    end
    return '0;
  endfunction

  task automatic clear_word();
    open_word = 1'b0;
    word_len  = 0;
    ends_in_q = 1'b0;
    for (int k = 0; k < PrefixDepth; k++) prefix[k] = 8'h00;
  endtask

  task automatic close_word();
    token_t tok;
    tok.kw   = lookup_keyword();
    tok.len  = TokLenW'(word_len);
    tok.line = word_line;
    tok.col  = word_col;
    expected_tokens.push_back(tok);
    clear_word();
  endtask

  task automatic take_char(input logic [7:0] c);
    if (word_len < PrefixDepth) prefix[word_len] = c;
    word_len++;
    ends_in_q = (c == CharQuestion);
  endtask

  task automatic scan_char(input logic [7:0] c, input logic [CoordW-1:0] ln,
                           input logic [CoordW-1:0] cl);
    if (open_word) begin
      if (opens_word(c) || is_numeral(c) || (c == CharQuestion)) begin
        take_char(c);
        if (word_len >= MAX_WORD_LEN) close_word();
      end else begin
        close_word();
      end
    end else if (opens_word(c)) begin
      clear_word();
      open_word = 1'b1;
      word_line = ln;
      word_col  = cl;
      take_char(c);
      if (word_len >= MAX_WORD_LEN) close_word();
    end
  endtask

  task automatic report(input string what, input int got_v, input int want_v);
    $display("%0t ns: token mismatch on %s: got %0d, expected %0d",
             $time, what, got_v, want_v);
    fail_tally++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t got;
    token_t want;
    if (!rst_ni) begin
      clear_word();
      word_line = '0;
      word_col  = '0;
      expected_tokens.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        scan_char(s_tdata_i[7:0], s_tdata_i[23:8], s_tdata_i[39:24]);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[42:0];
        if (m_tdata_i[47:43] != '0) report("pad bits", m_tdata_i[47:43], 0);
        if (expected_tokens.size() == 0) begin
          report("unexpected token, length", got.len, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (got.kw != want.kw) report("keyword_index", got.kw, want.kw);
          if (got.len != want.len) report("token_length", got.len, want.len);
          if (got.line != want.line) report("token_line", got.line, want.line);
          if (got.col != want.col) report("start_column", got.col, want.col);
        end
      end
    end
    error_count_o <= fail_tally;
    pending_o     <= expected_tokens.size();
  end

endmodule

>>> sim/identifier_keyword_scanner_tb.sv
// ----------------------------------------------------------------------------
// identifier_keyword_scanner_tb
// Feeds the scanner a short directed character sequence, then random words,
// keywords, near-miss keywords, overlong words and noise under three idling
// patterns; the checker beside the block predicts and compares the tokens.
// ----------------------------------------------------------------------------
module identifier_keyword_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ikw_pkg::*;

  localparam int unsigned MaxWordLen    = 63;
  localparam int          IdleLimit     = 2000;
  localparam int          ItemsPerPhase = 200;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  int                error_count;
  int                tokens_pending;
  int                send_idle_pct = 14;
  int                recv_idle_pct = 60;
  int                items_sent    = 0;
  int                idle_cycles   = 0;
  logic [CoordW-1:0] cur_line      = '0;
  logic [CoordW-1:0] cur_col       = '0;

  identifier_keyword_scanner #(
    .MAX_WORD_LEN(MaxWordLen)
  ) DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  identifier_keyword_scanner_checker #(
    .MAX_WORD_LEN(MaxWordLen)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .error_count_o(error_count),
    .pending_o    (tokens_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cur_col, cur_line, c};
    do @(posedge clk_i); while (!s_axis_tready);
    cur_col = cur_col + 1'b1;
    items_sent++;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) push_char(s[k]);
  endtask

  function automatic logic [7:0] first_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(8'h41, 8'h5a));
      1: return 8'($urandom_range(8'h61, 8'h7a));
      default: return CharUnderscore;
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'h41, 8'h5a));
      1: return 8'($urandom_range(8'h61, 8'h7a));
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: return CharUnderscore;
      default: return CharQuestion;
    endcase
  endfunction

  function automatic logic [7:0] separator();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h2f));
      1: return 8'($urandom_range(8'h80, 8'hff));
      2: return 8'($urandom_range(8'h5b, 8'h5e));
      default: return 8'($urandom_range(8'h7b, 8'h7f));
    endcase
  endfunction

  // one word (keyword, near miss, identifier or overlong) or a few noise bytes
  task automatic random_burst();
    logic [7:0] chars [$];
    int         pick;
    int         kw;
    int         n;
    pick     = $urandom_range(0, 99);
    cur_line = CoordW'($urandom);
    cur_col  = CoordW'($urandom);
    if (pick < 40) begin
      kw = $urandom_range(0, KwCount - 1);
      n  = KwLen[kw];
      for (int k = 0; k < n; k++) chars.push_back(KwText[kw][8*(n-1-k) +: 8]);
      case ($urandom_range(0, 9))
        0: chars.push_back(CharQuestion);
        1: chars.push_back(word_char());
        2: void'(chars.pop_back());
        3: chars[0] = chars[0] ^ 8'h20;
        default: ;
      endcase
    end else if (pick < 90) begin
      chars.push_back(first_char());
      repeat ($urandom_range(0, 11)) chars.push_back(word_char());
    end else if (pick < 95) begin
      chars.push_back(first_char());
      repeat ($urandom_range(54, 72)) chars.push_back(word_char());
    end else begin
      repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) != 0) chars.push_back(separator());
    foreach (chars[k]) push_char(chars[k]);
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_line = 16'h0000;
    cur_col  = 16'h0000;
    push_text("do ");
    cur_line = 16'hffff;
    cur_col  = 16'hfffd;
    push_text("Z9?");
    push_char(8'hff);
    // digit and question mark with no word open
    push_text("9?");
    cur_line = 16'h0000;
    cur_col  = 16'hffff;
    push_text("_if");
    push_char(8'h80);
    cur_line = 16'h5a5a;
    cur_col  = 16'ha5a5;
    push_text("continue");
    push_char(8'h00);
    push_text("if?.");

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) random_burst();
    end
    s_axis_tvalid <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (tokens_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if ((error_count == 0) && (tokens_pending == 0)) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
